// File: rtl/multilevel_round_robin_pick_core_assert.svh
// Assertion macros for the multilevel round-robin pick core.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef MULTILEVEL_ROUND_ROBIN_PICK_CORE_ASSERT_SVH
`define MULTILEVEL_ROUND_ROBIN_PICK_CORE_ASSERT_SVH

// Same-cycle implication.
`define MRRP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MRRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mrrp_pkg.sv
// Package for the multilevel round-robin pick core.
// Request/response payload types and fixed field widths; no dependencies.
`default_nettype none

package mrrp_pkg;

    localparam int LEVELS_DEF = 4;
    localparam int SLOTS_DEF  = 16;

    localparam int ID_W       = 6;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic FUNC_DISPATCH = 1'b0;
    localparam logic FUNC_PICK     = 1'b1;

    typedef struct packed {
        logic            func;
        logic [ID_W-1:0] callback_id;
    } req_t;

    typedef struct packed {
        logic            fired;
        logic [ID_W-1:0] fired_id;
        logic            any_pending;
    } rsp_t;

endpackage

`default_nettype wire

// File: rtl/multilevel_round_robin_pick_core.sv
// Multilevel round-robin pick core: top level, a single module.
// Depends on mrrp_pkg and multilevel_round_robin_pick_core_assert.svh.
//
// A dispatch request marks a registered callback pending and moves to the finish
// state. A pick request walks the levels through one shared priority encoder,
// one level per cycle: down the levels over the slots at and after each cursor,
// then back up over the slots before it, stopping at the first hit. The finish
// state loads the response register once it is free. One request is in flight
// at a time; the response register lets a new request be accepted while the
// previous response waits. Member masks are written through the cfg port; the
// user must do so only while the core is idle (the core does not enforce this).
`default_nettype none

`include "multilevel_round_robin_pick_core_assert.svh"

module multilevel_round_robin_pick_core #(
    parameter int LEVELS = mrrp_pkg::LEVELS_DEF,
    parameter int SLOTS  = mrrp_pkg::SLOTS_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_we,
    input  wire [mrrp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [mrrp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire                              req_valid,
    output logic                             req_ready,
    input  mrrp_pkg::req_t                   req,
    output logic                             rsp_valid,
    input  wire                              rsp_ready,
    output mrrp_pkg::rsp_t                   rsp
);

    import mrrp_pkg::*;

    localparam int LW = $clog2(LEVELS);
    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DOWN   = 2'd1;
    localparam logic [1:0] ST_UP     = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [LW-1:0]    lvl_reg, lvl_next;
    logic [SLOTS-1:0] members_reg [LEVELS];
    logic [SLOTS-1:0] pend_reg [LEVELS];
    logic [SLOTS-1:0] pend_next [LEVELS];
    logic [CW-1:0]    cursor_reg [LEVELS];
    logic [CW-1:0]    cursor_next [LEVELS];
    logic             fired_reg, fired_next;
    logic [ID_W-1:0]  fid_reg, fid_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg, rsp_next;

    logic             accept;
    logic             d_hit;
    logic [LW-1:0]    d_lvl;
    logic [SW-1:0]    d_slot;
    logic [SLOTS-1:0] win_mask;
    logic [SLOTS-1:0] cand;
    logic             hit;
    logic [SW-1:0]    hit_slot;
    logic             any_pend;
    logic [SLOTS+CFG_DATA_W-1:0] cfg_ext;

    assign accept    = req_valid && req_ready;
    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ext   = {{SLOTS{1'b0}}, cfg_data};

    // id -> level and slot
    always_comb
    begin
        d_hit  = 1'b0;
        d_lvl  = '0;
        d_slot = '0;
        for (int l = 0; l < LEVELS; l++)
        begin
            if (int'(req.callback_id) >= l * SLOTS && int'(req.callback_id) < (l + 1) * SLOTS)
            begin
                d_hit  = 1'b1;
                d_lvl  = LW'(l);
                d_slot = SW'(int'(req.callback_id) - l * SLOTS);
            end
        end
    end

    // shared scan unit: window select and priority encoder on the current level
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            win_mask[i] = (CW'(i) < cursor_reg[lvl_reg]);
            if (state_reg == ST_DOWN)
            begin
                win_mask[i] = !win_mask[i];
            end
        end
        cand     = pend_reg[lvl_reg] & members_reg[lvl_reg] & win_mask;
        hit      = 1'b0;
        hit_slot = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                hit      = 1'b1;
                hit_slot = SW'(i);
            end
        end
    end

    always_comb
    begin
        any_pend = 1'b0;
        for (int l = 0; l < LEVELS; l++)
        begin
            any_pend = any_pend | (|(pend_reg[l] & members_reg[l]));
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        lvl_next       = lvl_reg;
        pend_next      = pend_reg;
        cursor_next    = cursor_reg;
        fired_next     = fired_reg;
        fid_next       = fid_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    fired_next = 1'b0;
                    fid_next   = '0;
                    lvl_next   = '0;
                    if (req.func == FUNC_PICK)
                    begin
                        state_next = ST_DOWN;
                    end
                    else
                    begin
                        if (d_hit && members_reg[d_lvl][d_slot])
                        begin
                            pend_next[d_lvl][d_slot] = 1'b1;
                        end
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_DOWN, ST_UP:
            begin
                if (hit)
                begin
                    pend_next[lvl_reg][hit_slot] = 1'b0;
                    cursor_next[lvl_reg] = CW'(hit_slot) + CW'(1);
                    for (int l = 0; l < LEVELS; l++)
                    begin
                        if (LW'(l) < lvl_reg && members_reg[l] != '0)
                        begin
                            cursor_next[l] = '0;
                        end
                    end
                    fired_next = 1'b1;
                    fid_next   = ID_W'(int'(lvl_reg) * SLOTS + int'(hit_slot));
                    state_next = ST_FINISH;
                end
                else if (state_reg == ST_DOWN)
                begin
                    if (lvl_reg == LW'(LEVELS - 1))
                    begin
                        state_next = ST_UP;
                    end
                    else
                    begin
                        lvl_next = lvl_reg + LW'(1);
                    end
                end
                else
                begin
                    if (lvl_reg == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        lvl_next = lvl_reg - LW'(1);
                    end
                end
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.fired       = fired_reg;
                    rsp_next.fired_id    = fid_reg;
                    rsp_next.any_pending = any_pend;
                    rsp_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lvl_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            for (int l = 0; l < LEVELS; l++)
            begin
                members_reg[l] <= '0;
                pend_reg[l]    <= '0;
                cursor_reg[l]  <= CW'(SLOTS);
            end
        end
        else
        begin
            state_reg     <= state_next;
            lvl_reg       <= lvl_next;
            rsp_valid_reg <= rsp_valid_next;
            pend_reg      <= pend_next;
            cursor_reg    <= cursor_next;
            if (cfg_we && cfg_index < CFG_IDX_W'(LEVELS))
            begin
                members_reg[cfg_index[LW-1:0]] <= cfg_ext[SLOTS-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fired_reg <= fired_next;
        fid_reg   <= fid_next;
        rsp_reg   <= rsp_next;
    end

    `MRRP_ASSERT_NEXT(a_dispatch_no_fire, accept && req.func == FUNC_DISPATCH,
        state_reg == ST_FINISH && !fired_reg, "dispatch request must not fire")
    `MRRP_ASSERT_NEXT(a_fire_clears, (state_reg == ST_DOWN || state_reg == ST_UP) && hit,
        !pend_reg[$past(lvl_reg)][$past(hit_slot)] && state_reg == ST_FINISH,
        "fired slot must be cleared")
    `MRRP_ASSERT_NEXT(a_fire_cursor, (state_reg == ST_DOWN || state_reg == ST_UP) && hit,
        cursor_reg[$past(lvl_reg)] == CW'($past(hit_slot)) + CW'(1),
        "cursor must move past fired slot")
    `MRRP_ASSERT_NOW(a_busy_rsp_idle, state_reg == ST_DOWN && rsp_valid_reg && rsp.fired,
        int'(rsp.fired_id) < LEVELS * SLOTS,
        "fired id out of range")

endmodule

`default_nettype wire
